### design/qst_pkg.sv
package qst_pkg;

	typedef enum logic [1:0] {
		OP_BEGIN   = 2'd0,
		OP_OBSERVE = 2'd1,
		OP_CONSUME = 2'd2,
		OP_RESET   = 2'd3
	} qst_op_t;

	typedef enum logic [1:0] {
		ST_INVALID   = 2'd0,
		ST_WAITING   = 2'd1,
		ST_QUIESCENT = 2'd2
	} qst_status_t;

	localparam logic [7:0] STABLE_SAMPLES_RESET = 8'd3;
	localparam logic [7:0] STABLE_COUNT_MAX     = 8'd255;

	typedef struct packed {
		qst_op_t     opcode;
		logic [63:0] transaction_id;
		logic [31:0] pending_count;
		logic [63:0] generation;
		logic [63:0] token_nonce;
		logic [63:0] token_revision;
		logic        token_verified;
	} qst_cmd_t;

	typedef struct packed {
		qst_status_t observe_status;
		logic        accepted;
		logic        auth_valid;
		logic [63:0] auth_transaction;
		logic [63:0] auth_nonce;
		logic [63:0] auth_generation;
		logic [63:0] auth_revision;
	} qst_rsp_t;

endpackage

### design/qst_cmd_if.sv
interface qst_cmd_if;
	logic               valid;
	logic               ready;
	qst_pkg::qst_cmd_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### design/qst_rsp_if.sv
interface qst_rsp_if;
	logic               valid;
	logic               ready;
	qst_pkg::qst_rsp_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### design/quiescence_settle_tracker.sv
// Quiescence settle tracker.
// cmd: valid/ready channel of commands (begin, observe, consume, reset).
// rsp: valid/ready channel, exactly one result transaction per command.
// cfg_we/cfg_wdata: write of required_stable_samples; write only while idle.
// A command is captured into an input register on the cycle it is accepted;
// it is evaluated against the tracker state once the output register is free
// or being taken, and the result lands in the output register. Throughput is
// one command per cycle while rsp does not stall, set by the single pass
// of compares and 64-bit increments between the input and output registers.
// When rsp stalls, the output register holds its result and the input
// register holds one more command; cmd.ready drops only when both are full,
// and rises again in the cycle the result is taken.
// On arst_n low the tracker clears, the nonce counter returns to one, the
// threshold returns to three, and both pipeline slots empty.
module quiescence_settle_tracker (
	input  logic              clk,
	input  logic              arst_n,
	qst_cmd_if.sink           cmd,
	qst_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);

	logic [7:0]          req_q;
	logic                valid_s1;
	qst_pkg::qst_cmd_t   cmd_s1;
	logic                out_valid_q;
	qst_pkg::qst_rsp_t   rsp_q;

	logic [63:0] active_q;
	logic [63:0] nonce_q;
	logic [63:0] counter_q;
	logic [63:0] last_gen_q;
	logic [63:0] rev_q;
	logic [7:0]  stable_q;
	logic        seen_q;
	logic        settled_q;

	logic [63:0] n_active;
	logic [63:0] n_nonce;
	logic [63:0] n_counter;
	logic [63:0] n_last_gen;
	logic [63:0] n_rev;
	logic [7:0]  n_stable;
	logic        n_seen;
	logic        n_settled;
	qst_pkg::qst_rsp_t n_rsp;

	logic advance;
	logic cmd_fire;

	assign advance  = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cmd_fire = cmd.valid && cmd.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = rsp_q;

	always_comb begin
		logic [63:0] rev_inc;
		logic [63:0] base_nonce;
		logic [7:0]  cnt;
		logic        held;
		logic        auth_cur;
		logic        auth_nxt;

		n_active   = active_q;
		n_nonce    = nonce_q;
		n_counter  = counter_q;
		n_last_gen = last_gen_q;
		n_rev      = rev_q;
		n_stable   = stable_q;
		n_seen     = seen_q;
		n_settled  = settled_q;
		n_rsp      = '0;
		n_rsp.observe_status = qst_pkg::ST_INVALID;
		rev_inc    = rev_q + 64'd1;
		base_nonce = (counter_q == 64'd0) ? 64'd1 : counter_q;
		cnt        = 8'd0;
		held       = 1'b0;
		auth_cur   = (active_q != 64'd0) && (nonce_q != 64'd0) && (rev_q != 64'd0)
			&& seen_q && settled_q && (stable_q >= req_q);

		unique case (cmd_s1.opcode)
			qst_pkg::OP_BEGIN: begin
				if (cmd_s1.transaction_id != 64'd0 && active_q == 64'd0) begin
					n_counter  = base_nonce + 64'd1;
					n_active   = cmd_s1.transaction_id;
					n_nonce    = base_nonce;
					n_last_gen = 64'd0;
					n_rev      = 64'd0;
					n_stable   = 8'd0;
					n_seen     = 1'b0;
					n_settled  = 1'b0;
					n_rsp.accepted = 1'b1;
				end
			end
			qst_pkg::OP_OBSERVE: begin
				if (cmd_s1.transaction_id != 64'd0 && cmd_s1.transaction_id == active_q) begin
					if (rev_inc == 64'd0) begin
						n_active   = 64'd0;
						n_nonce    = 64'd0;
						n_last_gen = 64'd0;
						n_rev      = 64'd0;
						n_stable   = 8'd0;
						n_seen     = 1'b0;
						n_settled  = 1'b0;
					end else begin
						n_rev = rev_inc;
						if (settled_q) begin
							if (cmd_s1.pending_count == 32'd0 && seen_q
								&& cmd_s1.generation == last_gen_q) begin
								n_rsp.observe_status = qst_pkg::ST_QUIESCENT;
								held = 1'b1;
							end else begin
								n_settled = 1'b0;
								n_stable  = 8'd0;
							end
						end
						if (!held) begin
							if (cmd_s1.pending_count != 32'd0) begin
								n_last_gen = cmd_s1.generation;
								n_seen     = 1'b1;
								n_stable   = 8'd0;
								n_rsp.observe_status = qst_pkg::ST_WAITING;
							end else if (!seen_q || cmd_s1.generation != last_gen_q) begin
								n_last_gen = cmd_s1.generation;
								n_seen     = 1'b1;
								n_stable   = 8'd1;
								n_rsp.observe_status = qst_pkg::ST_WAITING;
							end else begin
								cnt = (n_stable < qst_pkg::STABLE_COUNT_MAX)
									? n_stable + 8'd1 : n_stable;
								n_stable = cnt;
								if (cnt < req_q) begin
									n_rsp.observe_status = qst_pkg::ST_WAITING;
								end else begin
									n_settled = 1'b1;
									n_rsp.observe_status = qst_pkg::ST_QUIESCENT;
								end
							end
						end
					end
				end
			end
			qst_pkg::OP_CONSUME: begin
				if (cmd_s1.token_verified && auth_cur
					&& cmd_s1.transaction_id == active_q
					&& cmd_s1.token_nonce == nonce_q
					&& cmd_s1.generation == last_gen_q
					&& cmd_s1.token_revision == rev_q) begin
					n_active   = 64'd0;
					n_nonce    = 64'd0;
					n_last_gen = 64'd0;
					n_rev      = 64'd0;
					n_stable   = 8'd0;
					n_seen     = 1'b0;
					n_settled  = 1'b0;
					n_rsp.accepted = 1'b1;
				end
			end
			qst_pkg::OP_RESET: begin
				if (cmd_s1.transaction_id != 64'd0 && cmd_s1.transaction_id == active_q) begin
					n_active   = 64'd0;
					n_nonce    = 64'd0;
					n_last_gen = 64'd0;
					n_rev      = 64'd0;
					n_stable   = 8'd0;
					n_seen     = 1'b0;
					n_settled  = 1'b0;
					n_rsp.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase

		auth_nxt = (n_active != 64'd0) && (n_nonce != 64'd0) && (n_rev != 64'd0)
			&& n_seen && n_settled && (n_stable >= req_q);
		n_rsp.auth_valid = auth_nxt;
		if (auth_nxt) begin
			n_rsp.auth_transaction = n_active;
			n_rsp.auth_nonce       = n_nonce;
			n_rsp.auth_generation  = n_last_gen;
			n_rsp.auth_revision    = n_rev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q       <= qst_pkg::STABLE_SAMPLES_RESET;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			active_q    <= '0;
			nonce_q     <= '0;
			counter_q   <= 64'd1;
			last_gen_q  <= '0;
			rev_q       <= '0;
			stable_q    <= '0;
			seen_q      <= 1'b0;
			settled_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				req_q <= cfg_wdata;
			end
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				active_q   <= n_active;
				nonce_q    <= n_nonce;
				counter_q  <= n_counter;
				last_gen_q <= n_last_gen;
				rev_q      <= n_rev;
				stable_q   <= n_stable;
				seen_q     <= n_seen;
				settled_q  <= n_settled;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_s1 <= cmd.payload;
		end
		if (advance) begin
			rsp_q <= n_rsp;
		end
	end

	a_nonce_tracks_id: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q == 64'd0) == (nonce_q == 64'd0))
		else $error("session nonce and transaction id disagree on occupancy");

	a_settled_needs_gen: assert property (@(posedge clk) disable iff (!arst_n)
		settled_q |-> seen_q)
		else $error("settled without a seen generation");

	a_auth_revision: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_q.auth_valid) |-> (rsp_q.auth_revision != 64'd0
			&& rsp_q.auth_nonce != 64'd0))
		else $error("authorization issued with zero revision or nonce");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> valid_s1)
		else $error("accepted transaction lost before evaluation");

endmodule

### verif/quiescence_settle_tracker_tb.sv
module quiescence_settle_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qst_pkg::*;

	localparam int PERIOD       = 20;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int SETTLE       = 8;
	localparam int REPORT_LIMIT = 40;
	localparam int RANDOM_ITEMS = 600;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	qst_cmd_if cmd_ch();
	qst_rsp_if rsp_ch();

	quiescence_settle_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(PERIOD / 2) clk = ~clk;

	qst_rsp_t   awaited_rsp[$];
	int         err_count   = 0;
	int         sent_count  = 0;
	int         cycle_count = 0;
	int         rsp_stall   = 0;
	bit         quiet       = 1'b0;

	logic [7:0]  m_threshold;
	logic [63:0] m_active;
	logic [63:0] m_nonce;
	logic [63:0] m_counter;
	logic [63:0] m_last_gen;
	logic [63:0] m_rev;
	logic [7:0]  m_stable;
	logic        m_gen_seen;
	logic        m_settled;

	function automatic void clear_tracker();
		m_active   = '0;
		m_nonce    = '0;
		m_last_gen = '0;
		m_rev      = '0;
		m_stable   = '0;
		m_gen_seen = 1'b0;
		m_settled  = 1'b0;
	endfunction

	function automatic logic auth_open();
		return m_active != 0 && m_nonce != 0 && m_rev != 0 && m_gen_seen && m_settled &&
			m_stable >= m_threshold;
	endfunction

	function automatic qst_status_t observe_sample(logic [63:0] id, logic [31:0] pend,
			logic [63:0] gen);
		if (id == 0 || id != m_active)
			return ST_INVALID;
		m_rev = m_rev + 64'd1;
		if (m_rev == 0) begin
			clear_tracker();
			return ST_INVALID;
		end
		if (m_settled) begin
			if (pend == 0 && m_gen_seen && gen == m_last_gen)
				return ST_QUIESCENT;
			m_settled = 1'b0;
			m_stable  = '0;
		end
		if (pend != 0) begin
			m_last_gen = gen;
			m_gen_seen = 1'b1;
			m_stable   = '0;
			return ST_WAITING;
		end
		if (!m_gen_seen || gen != m_last_gen) begin
			m_last_gen = gen;
			m_gen_seen = 1'b1;
			m_stable   = 8'd1;
			return ST_WAITING;
		end
		if (m_stable < STABLE_COUNT_MAX)
			m_stable = m_stable + 8'd1;
		if (m_stable < m_threshold)
			return ST_WAITING;
		m_settled = 1'b1;
		return ST_QUIESCENT;
	endfunction

	function automatic qst_rsp_t advance_tracker(qst_cmd_t c);
		qst_rsp_t    r;
		logic [63:0] n;
		r = '0;
		r.observe_status = ST_INVALID;
		case (c.opcode)
			OP_BEGIN: begin
				if (c.transaction_id != 0 && m_active == 0) begin
					n = m_counter;
					if (n == 0)
						n = 64'd1;
					m_counter = n + 64'd1;
					clear_tracker();
					m_active   = c.transaction_id;
					m_nonce    = n;
					r.accepted = 1'b1;
				end
			end
			OP_OBSERVE: begin
				r.observe_status = observe_sample(c.transaction_id, c.pending_count, c.generation);
			end
			OP_CONSUME: begin
				if (c.token_verified && auth_open() && c.transaction_id == m_active &&
						c.token_nonce == m_nonce && c.generation == m_last_gen &&
						c.token_revision == m_rev) begin
					clear_tracker();
					r.accepted = 1'b1;
				end
			end
			OP_RESET: begin
				if (c.transaction_id != 0 && c.transaction_id == m_active) begin
					clear_tracker();
					r.accepted = 1'b1;
				end
			end
		endcase
		if (auth_open()) begin
			r.auth_valid       = 1'b1;
			r.auth_transaction = m_active;
			r.auth_nonce       = m_nonce;
			r.auth_generation  = m_last_gen;
			r.auth_revision    = m_rev;
		end
		return r;
	endfunction

	task automatic report(input string msg);
		err_count++;
		if (err_count <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_rsp(input qst_rsp_t got);
		qst_rsp_t want;
		if (awaited_rsp.size() == 0) begin
			report("result transaction with none awaited");
			return;
		end
		want = awaited_rsp.pop_front();
		if (got.observe_status !== want.observe_status)
			report($sformatf("observe_status got %0d want %0d",
				got.observe_status, want.observe_status));
		if (got.accepted !== want.accepted)
			report($sformatf("accepted got %b want %b", got.accepted, want.accepted));
		if (got.auth_valid !== want.auth_valid)
			report($sformatf("auth_valid got %b want %b", got.auth_valid, want.auth_valid));
		if (got.auth_transaction !== want.auth_transaction)
			report($sformatf("auth_transaction got %h want %h",
				got.auth_transaction, want.auth_transaction));
		if (got.auth_nonce !== want.auth_nonce)
			report($sformatf("auth_nonce got %h want %h", got.auth_nonce, want.auth_nonce));
		if (got.auth_generation !== want.auth_generation)
			report($sformatf("auth_generation got %h want %h",
				got.auth_generation, want.auth_generation));
		if (got.auth_revision !== want.auth_revision)
			report($sformatf("auth_revision got %h want %h",
				got.auth_revision, want.auth_revision));
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			check_rsp(rsp_ch.payload);
			rsp_stall = quiet ? 0 : $urandom_range(0, 14);
		end else if (rsp_stall > 0) begin
			rsp_stall--;
		end
		rsp_ch.ready <= (rsp_stall == 0);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("quiescence_settle_tracker regression: fail");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] flip_bit(logic [63:0] v);
		return v ^ (64'd1 << $urandom_range(0, 63));
	endfunction

	function automatic logic [31:0] rand_pending();
		logic [31:0] p;
		p = $urandom;
		if (p == 0)
			p = 32'd1;
		return p;
	endfunction

	function automatic logic [63:0] pick_id();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: v = '1;
			1: v = 64'($urandom_range(1, 8));
			default: v = rand64();
		endcase
		if (v == 0)
			v = 64'd1;
		return v;
	endfunction

	function automatic logic [63:0] pick_gen();
		return ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 3)) : rand64();
	endfunction

	function automatic qst_cmd_t make_cmd(qst_op_t op, logic [63:0] id, logic [31:0] pend,
			logic [63:0] gen, logic [63:0] tnonce, logic [63:0] trev, logic tver);
		qst_cmd_t c;
		c.opcode         = op;
		c.transaction_id = id;
		c.pending_count  = pend;
		c.generation     = gen;
		c.token_nonce    = tnonce;
		c.token_revision = trev;
		c.token_verified = tver;
		return c;
	endfunction

	task automatic send_cmd(input qst_cmd_t c);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= c;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		awaited_rsp.push_back(advance_tracker(c));
		sent_count++;
	endtask

	task automatic send_observe(input logic [63:0] id, input logic [31:0] pend,
			input logic [63:0] gen);
		send_cmd(make_cmd(OP_OBSERVE, id, pend, gen, rand64(), rand64(), $urandom_range(0, 1)));
	endtask

	task automatic send_token(input logic tver);
		send_cmd(make_cmd(OP_CONSUME, m_active, $urandom, m_last_gen, m_nonce, m_rev, tver));
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && awaited_rsp.size() != 0; i++)
			@(posedge clk);
		if (awaited_rsp.size() != 0) begin
			report($sformatf("%0d result transactions never arrived", awaited_rsp.size()));
			awaited_rsp.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [7:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		m_threshold = v;
	endtask

	task automatic send_noise();
		qst_cmd_t c;
		c.opcode = qst_op_t'($urandom_range(0, 3));
		case ($urandom_range(0, 5))
			0, 1: c.transaction_id = m_active;
			2: c.transaction_id = '0;
			default: c.transaction_id = rand64();
		endcase
		c.pending_count  = $urandom_range(0, 1) ? 32'd0 : 32'($urandom);
		c.generation     = $urandom_range(0, 1) ? m_last_gen : rand64();
		c.token_nonce    = $urandom_range(0, 1) ? m_nonce : rand64();
		c.token_revision = $urandom_range(0, 1) ? m_rev : rand64();
		c.token_verified = $urandom_range(0, 1);
		send_cmd(c);
	endtask

	task automatic run_session();
		logic [63:0] id;
		logic [63:0] gen;
		qst_cmd_t    c;
		int          n_idle;
		quiet = ($urandom_range(0, 4) == 0);
		if (m_active != 0 && $urandom_range(0, 3) != 0)
			send_cmd(make_cmd(OP_RESET, m_active, $urandom, rand64(), rand64(), rand64(), 1'b1));
		send_cmd(make_cmd(OP_BEGIN, pick_id(), $urandom, rand64(), rand64(), rand64(),
			$urandom_range(0, 1)));
		id  = m_active;
		gen = pick_gen();
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 2) == 0)
				gen = pick_gen();
			send_observe(id, rand_pending(), gen);
		end
		n_idle = int'(m_threshold) + $urandom_range(1, 3);
		repeat (n_idle) begin
			if (m_threshold < 32 && $urandom_range(0, 15) == 0) begin
				case ($urandom_range(0, 2))
					0: send_observe(id, rand_pending(), gen);
					1: begin
						gen = pick_gen();
						send_observe(id, 32'd0, gen);
					end
					default: send_observe(flip_bit(id), 32'd0, gen);
				endcase
			end else begin
				send_observe(id, 32'd0, gen);
			end
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				c = make_cmd(OP_CONSUME, m_active, $urandom, m_last_gen, m_nonce, m_rev, 1'b1);
				send_cmd(c);
				if ($urandom_range(0, 2) == 0)
					send_cmd(c);
			end
			5: begin
				c = make_cmd(OP_CONSUME, m_active, $urandom, m_last_gen, m_nonce, m_rev, 1'b1);
				case ($urandom_range(0, 4))
					0: c.token_verified = 1'b0;
					1: c.transaction_id = flip_bit(c.transaction_id);
					2: c.token_nonce    = flip_bit(c.token_nonce);
					3: c.generation     = flip_bit(c.generation);
					default: c.token_revision = flip_bit(c.token_revision);
				endcase
				send_cmd(c);
			end
			6: send_cmd(make_cmd(OP_RESET, id, $urandom, rand64(), rand64(), rand64(), 1'b0));
			7: send_cmd(make_cmd(OP_RESET, flip_bit(id), $urandom, rand64(), rand64(),
				rand64(), 1'b1));
			8: send_cmd(make_cmd(OP_BEGIN, pick_id(), $urandom, rand64(), rand64(), rand64(),
				1'b1));
			default: ;
		endcase
	endtask

	task automatic test_directed();
		quiet = 1'b0;
		send_observe(64'd1, 32'd0, 64'd0);
		send_cmd(make_cmd(OP_CONSUME, '1, '1, '1, '1, '1, 1'b1));
		send_cmd(make_cmd(OP_RESET, '0, '0, '0, '0, '0, 1'b0));
		send_cmd(make_cmd(OP_BEGIN, '0, '0, '0, '0, '0, 1'b0));
		send_cmd(make_cmd(OP_BEGIN, '1, '1, '1, '1, '1, 1'b1));
		send_cmd(make_cmd(OP_BEGIN, 64'd5, '0, '0, '0, '0, 1'b0));
		send_observe('1, '1, '1);
		repeat (4) send_observe('1, 32'd0, '1);
		send_token(1'b0);
		send_token(1'b1);
		send_cmd(make_cmd(OP_BEGIN, 64'd1, '0, '0, '0, '0, 1'b0));
		send_observe(64'd1, 32'd0, 64'd0);
		repeat (3) send_observe(64'd1, 32'd0, 64'd1);
		send_observe(64'd1, 32'd1, 64'd1);
		send_cmd(make_cmd(OP_RESET, 64'd2, '0, '0, '0, '0, 1'b1));
		send_cmd(make_cmd(OP_RESET, 64'd1, '0, '0, '0, '0, 1'b1));
		send_observe(64'd1, 32'd0, 64'd1);
	endtask

	task automatic test_threshold_zero();
		set_threshold(8'd0);
		send_cmd(make_cmd(OP_BEGIN, 64'd7, '0, '0, '0, '0, 1'b0));
		send_observe(64'd7, 32'd0, 64'd7);
		send_observe(64'd7, 32'd0, 64'd7);
		send_token(1'b1);
		send_cmd(make_cmd(OP_BEGIN, 64'd9, '0, '0, '0, '0, 1'b0));
		send_observe(64'd9, 32'd3, 64'd2);
		send_observe(64'd9, 32'd0, 64'd2);
		send_token(1'b1);
		repeat (4) run_session();
	endtask

	task automatic test_threshold_max();
		set_threshold(8'd255);
		repeat (2) run_session();
		set_threshold(8'd1);
		repeat (3) run_session();
	endtask

	task automatic test_random_sessions();
		int         first;
		int         phase;
		logic [7:0] level;
		first = sent_count;
		phase = 0;
		while (sent_count - first < RANDOM_ITEMS) begin
			case (phase % 6)
				0: level = 8'd1;
				1: level = 8'd2;
				2: level = STABLE_SAMPLES_RESET;
				3: level = 8'd4;
				4: level = 8'd9;
				default: level = 8'($urandom_range(1, 20));
			endcase
			set_threshold(level);
			repeat (8) begin
				if ($urandom_range(0, 3) == 0) begin
					quiet = ($urandom_range(0, 3) == 0);
					repeat ($urandom_range(1, 6)) send_noise();
				end
				run_session();
			end
			phase++;
		end
	endtask

	task automatic finish_run();
		drain_results();
		if (err_count == 0)
			$display("quiescence_settle_tracker regression: pass");
		else
			$display("quiescence_settle_tracker regression: fail");
		$finish;
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.payload = '0;
		rsp_ch.ready   = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		m_threshold    = STABLE_SAMPLES_RESET;
		m_counter      = 64'd1;
		clear_tracker();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_threshold_zero();
		test_threshold_max();
		test_random_sessions();
		finish_run();
	end

endmodule
